>>> hw/rtl/nbody_energy_momentum_diagnostics_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the n-body diagnostics core
// Shared clocked assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef NBODY_ENERGY_MOMENTUM_DIAGNOSTICS_CORE_MACROS_SVH
`define NBODY_ENERGY_MOMENTUM_DIAGNOSTICS_CORE_MACROS_SVH

// condition holds in the same cycle
`define NBEM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition holds in the next cycle
`define NBEM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/nbem_pkg.sv
// ----------------------------------------------------------------------------
// nbem_pkg
// Types, status codes and saturating helpers for the n-body diagnostics core.
// ----------------------------------------------------------------------------
package nbem_pkg;

	localparam int DW         = 64;
	localparam int MAX_BODIES = 256;
	localparam int AW         = $clog2(MAX_BODIES);
	localparam int CW         = AW + 1;

	localparam logic signed [DW-1:0] S64_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] S64_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] G_RESET = 64'sh0000_0001_0000_0000;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_G    = 3'd1,
		ST_NEG_EPS  = 3'd2,
		ST_COINCIDE = 3'd3,
		ST_ZERO_M   = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_GRAV = 1'b0,
		REG_SOFT = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LVV, S_LMV, S_LMP, S_LKE,
		S_PSTART, S_PEPS, S_POUTER, S_PRDI, S_PGM, S_PINNER, S_PRDJ,
		S_PSQ, S_PEPSADD, S_PSQRT, S_PQ, S_PDIV,
		S_FIN, S_CDIV, S_EMIT
	} state_t;

	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [DW-1:0] r;
		r = a + b;
		if ((a[DW-1] == b[DW-1]) && (r[DW-1] != a[DW-1]))
			return a[DW-1] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [DW-1:0] r;
		r = a - b;
		if ((a[DW-1] != b[DW-1]) && (r[DW-1] != a[DW-1]))
			return a[DW-1] ? S64_MIN : S64_MAX;
		return r;
	endfunction

endpackage

>>> hw/rtl/nbody_energy_momentum_diagnostics_core.sv
// ----------------------------------------------------------------------------
// nbody_energy_momentum_diagnostics_core
// Energy, momentum and center-of-mass diagnostics for a softened n-body set.
// ----------------------------------------------------------------------------
// Usage:
//   Bodies arrive on the s_ stream, one request per body, tlast on the last.
//   Up to 256 bodies are stored; further bodies are dropped. Each stored body
//   takes ten multiplies on the shared multiplier (issue, busy steps,
//   hand-off) after it is accepted. After the last body the pair sweep runs:
//   each unordered pair costs the 48-step root and the 96-step divide of
//   the shared radix-2 unit plus four multiplies. Then three 96-step
//   divides form the center of mass (none when the total mass is zero),
//   and one result request appears on the m_ stream.
//   s_tready is high only while the sequencer is idle; a waiting result does
//   not block loading of the next system, only the next result's emission.
//   If the receiver stalls, the result stays in the output register.
//   Reset clears accumulators, body count, output valid and sets G = 1.0,
//   softening = 0. The body memory needs no clearing pass. cfg_we writes register
//   cfg_addr (0: G, 1: softening); the user writes only while idle (unenforced).
// ----------------------------------------------------------------------------
module nbody_energy_momentum_diagnostics_core import nbem_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [447:0] s_tdata,  // mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic         s_tlast,  // last_body
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [583:0] m_tdata,  // kinetic, potential, total, mom_x/y/z, com_x/y/z, status
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [63:0]  cfg_wdata
);

	state_t state_q, state_d;

	logic signed [DW-1:0] g_q, eps_q;
	logic signed [DW-1:0] m_q, v2_q, kin_q, mass_q, eps2_q;
	logic signed [DW-1:0] p_q [3];
	logic signed [DW-1:0] v_q [3];
	logic signed [DW-1:0] mom_q [3];
	logic signed [DW-1:0] wpos_q [3];
	logic signed [DW-1:0] pi_q [3];
	logic signed [DW-1:0] d_q [3];
	logic signed [DW-1:0] com_q [3];
	logic signed [DW-1:0] mi_q, mj_q, gm_q, s_q, dist_q, qm_q, pot_q, total_q;
	logic                 last_q, issued_q, m_tvalid_q;
	logic [1:0]           k_q;
	logic [CW-1:0]        count_q, i_q, j_q;
	status_t              status_q;
	logic [583:0]         m_tdata_q;

	logic [255:0] body_mem [MAX_BODIES];
	logic [255:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic                 mul_start, mul_sh33, mul_done;
	logic signed [DW-1:0] mul_a, mul_b, mul_res;
	logic                 dsq_div, dsq_sqrt, dsq_done;
	logic signed [DW-1:0] dsq_num, dsq_den, dsq_res;
	logic                 is_mul, is_dsq, out_free, accept;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	nbem_mul u_mul (
		.clk, .arst_n, .start(mul_start), .sh33(mul_sh33),
		.a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
	);

	nbem_dsq u_dsq (
		.clk, .arst_n, .start_div(dsq_div), .start_sqrt(dsq_sqrt),
		.num(dsq_num), .den(dsq_den), .done(dsq_done), .res(dsq_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accept) state_d = !count_q[CW-1] ? S_LVV :
					(s_tlast ? S_PSTART : S_IDLE);
			S_LVV:     if (mul_done) state_d = S_LMV;
			S_LMV:     if (mul_done) state_d = S_LMP;
			S_LMP:     if (mul_done) state_d = (k_q == 2'd2) ? S_LKE : S_LVV;
			S_LKE:     if (mul_done) state_d = last_q ? S_PSTART : S_IDLE;
			S_PSTART:  state_d = (g_q <= 0 || eps_q < 0) ? S_FIN : S_PEPS;
			S_PEPS:    if (mul_done) state_d = S_POUTER;
			S_POUTER:  state_d = (i_q >= count_q) ? S_FIN : S_PRDI;
			S_PRDI:    state_d = S_PGM;
			S_PGM:     if (mul_done) state_d = S_PINNER;
			S_PINNER:  state_d = (j_q >= count_q) ? S_POUTER : S_PRDJ;
			S_PRDJ:    state_d = S_PSQ;
			S_PSQ:     if (mul_done) state_d = (k_q == 2'd2) ? S_PEPSADD : S_PSQ;
			S_PEPSADD: state_d = S_PSQRT;
			S_PSQRT:   if (dsq_done) state_d = (dsq_res == 0) ? S_FIN : S_PQ;
			S_PQ:      if (mul_done) state_d = S_PDIV;
			S_PDIV:    if (dsq_done) state_d = S_PINNER;
			S_FIN:     state_d = (mass_q == 0) ? S_EMIT : S_CDIV;
			S_CDIV:    if (dsq_done && k_q == 2'd2) state_d = S_EMIT;
			S_EMIT:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// unit operand select and start strobes
	always_comb begin
		mul_a    = v_q[k_q];
		mul_b    = v_q[k_q];
		mul_sh33 = 1'b0;
		dsq_num  = wpos_q[k_q];
		dsq_den  = mass_q;
		is_mul   = 1'b0;
		is_dsq   = 1'b0;
		rd_addr  = i_q[AW-1:0];
		unique case (state_q)
			S_LVV:  is_mul = 1'b1;
			S_LMV:  begin is_mul = 1'b1; mul_a = m_q; end
			S_LMP:  begin is_mul = 1'b1; mul_a = m_q; mul_b = p_q[k_q]; end
			S_LKE:  begin is_mul = 1'b1; mul_a = m_q; mul_b = v2_q; mul_sh33 = 1'b1; end
			S_PEPS: begin is_mul = 1'b1; mul_a = eps_q; mul_b = eps_q; end
			S_PGM:  begin is_mul = 1'b1; mul_a = g_q; mul_b = mi_q; end
			S_PSQ:  begin is_mul = 1'b1; mul_a = d_q[k_q]; mul_b = d_q[k_q]; end
			S_PQ:   begin is_mul = 1'b1; mul_a = gm_q; mul_b = mj_q; end
			S_PSQRT: begin is_dsq = 1'b1; dsq_num = s_q; end
			S_PDIV: begin is_dsq = 1'b1; dsq_num = qm_q; dsq_den = dist_q; end
			S_CDIV: is_dsq = 1'b1;
			S_PINNER: rd_addr = j_q[AW-1:0];
			default: ;
		endcase
		mul_start = is_mul && !issued_q;
		dsq_sqrt  = is_dsq && !issued_q && (state_q == S_PSQRT);
		dsq_div   = is_dsq && !issued_q && (state_q != S_PSQRT);
	end

	assign s_tready = (state_q == S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q   <= G_RESET;
			eps_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_GRAV: g_q   <= cfg_wdata;
				REG_SOFT: eps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// body memory
	always_ff @(posedge clk) begin
		if (state_q == S_LKE && mul_done)
			body_mem[count_q[AW-1:0]] <= {m_q, p_q[0], p_q[1], p_q[2]};
		rd_q <= body_mem[rd_addr];
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			kin_q      <= '0;
			mass_q     <= '0;
			status_q   <= ST_OK;
			for (int n = 0; n < 3; n++) begin
				mom_q[n]  <= '0;
				wpos_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (mul_start || dsq_div || dsq_sqrt)
				issued_q <= 1'b1;
			if (mul_done || dsq_done)
				issued_q <= 1'b0;
			// in S_EMIT the emit arm below owns the valid flag
			if (m_tvalid_q && m_tready && state_q != S_EMIT)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (accept) begin
					m_q    <= s_tdata[63:0];
					p_q[0] <= s_tdata[127:64];
					p_q[1] <= s_tdata[191:128];
					p_q[2] <= s_tdata[255:192];
					v_q[0] <= s_tdata[319:256];
					v_q[1] <= s_tdata[383:320];
					v_q[2] <= s_tdata[447:384];
					last_q <= s_tlast;
					v2_q   <= '0;
					k_q    <= '0;
				end
				S_LVV: if (mul_done) v2_q <= sat_add(v2_q, mul_res);
				S_LMV: if (mul_done) mom_q[k_q] <= sat_add(mom_q[k_q], mul_res);
				S_LMP: if (mul_done) begin
					wpos_q[k_q] <= sat_add(wpos_q[k_q], mul_res);
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				S_LKE: if (mul_done) begin
					kin_q   <= sat_add(kin_q, mul_res);
					mass_q  <= sat_add(mass_q, m_q);
					count_q <= count_q + 1'b1;
				end
				S_PSTART: begin
					pot_q <= '0;
					i_q   <= '0;
					if (g_q <= 0)       status_q <= ST_BAD_G;
					else if (eps_q < 0) status_q <= ST_NEG_EPS;
					else                status_q <= ST_OK;
				end
				S_PEPS: if (mul_done) eps2_q <= mul_res;
				S_PRDI: begin
					mi_q    <= rd_q[255:192];
					pi_q[0] <= rd_q[191:128];
					pi_q[1] <= rd_q[127:64];
					pi_q[2] <= rd_q[63:0];
					j_q     <= i_q + 1'b1;
				end
				S_PGM: if (mul_done) gm_q <= mul_res;
				S_PINNER: if (j_q >= count_q) i_q <= i_q + 1'b1;
				S_PRDJ: begin
					mj_q   <= rd_q[255:192];
					d_q[0] <= sat_sub(rd_q[191:128], pi_q[0]);
					d_q[1] <= sat_sub(rd_q[127:64], pi_q[1]);
					d_q[2] <= sat_sub(rd_q[63:0], pi_q[2]);
					k_q    <= '0;
				end
				S_PSQ: if (mul_done) begin
					s_q <= (k_q == 2'd0) ? mul_res : sat_add(s_q, mul_res);
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				S_PEPSADD: s_q <= sat_add(s_q, eps2_q);
				S_PSQRT: if (dsq_done) begin
					dist_q <= dsq_res;
					if (dsq_res == 0) status_q <= ST_COINCIDE;
				end
				S_PQ: if (mul_done) qm_q <= mul_res;
				S_PDIV: if (dsq_done) begin
					pot_q <= sat_sub(pot_q, dsq_res);
					j_q   <= j_q + 1'b1;
				end
				S_FIN: begin
					if (status_q != ST_OK) begin
						pot_q   <= '0;
						total_q <= '0;
					end else begin
						total_q <= sat_add(kin_q, pot_q);
					end
					if (mass_q == 0 && status_q == ST_OK)
						status_q <= ST_ZERO_M;
					for (int n = 0; n < 3; n++)
						com_q[n] <= '0;
					k_q <= '0;
				end
				S_CDIV: if (dsq_done) begin
					com_q[k_q] <= dsq_res;
					k_q <= k_q + 2'd1;
				end
				S_EMIT: if (out_free) begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= {5'd0, status_q, com_q[2], com_q[1], com_q[0],
						mom_q[2], mom_q[1], mom_q[0], total_q, pot_q, kin_q};
					count_q <= '0;
					kin_q   <= '0;
					mass_q  <= '0;
					for (int n = 0; n < 3; n++) begin
						mom_q[n]  <= '0;
						wpos_q[n] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/nbem_mul.sv
// ----------------------------------------------------------------------------
// nbem_mul
// Shared Q32.32 multiplier: 64x64 signed product from four 32x32 partial
// products, then floor shift by 32 or 33 and saturation.
// ----------------------------------------------------------------------------
module nbem_mul import nbem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 sh33,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic                 done,
	output logic signed [DW-1:0] res
);

	logic [DW-1:0]   ma_q, mb_q;
	logic            neg_q, sh33_q, busy_q, done_q;
	logic [2*DW-1:0] acc_q;
	logic [2:0]      step_q;
	logic signed [DW-1:0] res_q;

	logic [31:0]     pa, pb;
	logic [DW-1:0]   pp;
	logic [2*DW-1:0] pp_sh;
	logic [2*DW-1:0] prod;
	logic signed [2*DW-1:0] shr;

	// partial product select and alignment
	always_comb begin
		pa    = step_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb    = step_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp    = {32'd0, pa} * {32'd0, pb};
		pp_sh = {64'd0, pp} << (7'd32 * ({6'd0, step_q[0]} + {6'd0, step_q[1]}));
		prod  = neg_q ? (~acc_q + 128'd1) : acc_q;
		shr   = sh33_q ? ($signed(prod) >>> 33) : ($signed(prod) >>> 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= a[DW-1] ? (64'd0 - a) : a;
			mb_q   <= b[DW-1] ? (64'd0 - b) : b;
			neg_q  <= a[DW-1] ^ b[DW-1];
			sh33_q <= sh33;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				if ((&shr[2*DW-1:DW-1]) || !(|shr[2*DW-1:DW-1]))
					res_q <= shr[DW-1:0];
				else
					res_q <= shr[2*DW-1] ? S64_MIN : S64_MAX;
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> hw/rtl/nbem_dsq.sv
// ----------------------------------------------------------------------------
// nbem_dsq
// Shared radix-2 divide / square root unit. Divide: (num*2^32)/den toward
// zero, saturated, 96 steps. Root: floor(sqrt(s*2^32)), 48 steps.
// ----------------------------------------------------------------------------
module nbem_dsq import nbem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start_div,
	input  logic                 start_sqrt,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 done,
	output logic signed [DW-1:0] res
);

	logic [95:0]   x_q, q_q;
	logic [65:0]   rem_q;
	logic [DW-1:0] d_q;
	logic          neg_q, sqrt_q, busy_q, fin_q, done_q;
	logic [6:0]    cnt_q;
	logic signed [DW-1:0] res_q;

	logic [65:0]   remsh, cmpv, diff;
	logic          qbit;
	logic [DW-1:0] qq, limit;

	// one step of the shared subtractor
	always_comb begin
		remsh = sqrt_q ? {rem_q[63:0], x_q[95:94]} : {rem_q[64:0], x_q[95]};
		cmpv  = sqrt_q ? {16'd0, q_q[47:0], 2'b01} : {2'b00, d_q};
		qbit  = (remsh >= cmpv);
		diff  = remsh - cmpv;
		qq    = q_q[63:0];
		limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start_div || start_sqrt) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= start_sqrt ? 7'd47 : 7'd95;
			end else if (busy_q) begin
				if (fin_q) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (cnt_q == 7'd0) begin
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div || start_sqrt) begin
			sqrt_q <= start_sqrt;
			rem_q  <= '0;
			q_q    <= '0;
			if (start_sqrt) begin
				x_q   <= {num, 32'd0};
				neg_q <= 1'b0;
			end else begin
				x_q   <= {(num[DW-1] ? (64'd0 - num) : num), 32'd0};
				d_q   <= den[DW-1] ? (64'd0 - den) : den;
				neg_q <= num[DW-1] ^ den[DW-1];
			end
		end else if (busy_q && !fin_q) begin
			rem_q <= qbit ? diff : remsh;
			q_q   <= {q_q[94:0], qbit};
			x_q   <= sqrt_q ? {x_q[93:0], 2'b00} : {x_q[94:0], 1'b0};
		end else if (fin_q) begin
			if (sqrt_q)
				res_q <= {16'd0, q_q[47:0]};
			else if ((|q_q[95:64]) || (qq > limit))
				res_q <= neg_q ? S64_MIN : S64_MAX;
			else
				res_q <= neg_q ? (64'd0 - qq) : qq;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> hw/rtl/nbem_checker.sv
// ----------------------------------------------------------------------------
// nbem_checker
// Port-level checks for the n-body diagnostics core, bound to the top level.
// ----------------------------------------------------------------------------
`include "nbody_energy_momentum_diagnostics_core_macros.svh"

module nbem_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [583:0] m_tdata
);

	logic [2:0] st_code;
	logic       st_err;

	assign st_code = m_tdata[578:576];
	assign st_err  = (st_code != 3'd0) && (st_code != 3'd4);

	// a stalled result stays offered
	`NBEM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
	// status code is in range
	`NBEM_ASSERT_SAME(a_status, m_tvalid, st_code <= 3'd4)
	// error status zeroes potential and total
	`NBEM_ASSERT_SAME(a_err_zero, m_tvalid && st_err, m_tdata[191:64] == 128'd0)
	// the last body starts the pair sweep, so input closes
	`NBEM_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind nbody_energy_momentum_diagnostics_core nbem_checker u_nbem_checker (.*);

>>> sim/nbody_energy_momentum_diagnostics_core_tb.sv
// ----------------------------------------------------------------------------
// nbody_energy_momentum_diagnostics_core_tb
// Streams body sets into the n-body diagnostics core under random idling,
// predicts every diagnostic request in Q32.32 and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbody_energy_momentum_diagnostics_core_tb;
	import nbem_pkg::*;

	typedef logic signed [63:0] q32_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		q32_t m;
		q32_t p[3];
		q32_t v[3];
		logic last;
	} body_t;

	typedef struct {
		q32_t f[9];
		status_t st;
	} diag_t;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int LONG_HOLD      = 60000;
	localparam q32_t ONE          = 64'sh0000_0001_0000_0000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [447:0] s_tdata = '0;  // mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	logic         s_tlast = 1'b0;  // last_body
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [583:0] m_tdata;  // kinetic, potential, total, mom_x/y/z, com_x/y/z, status
	logic         cfg_we = 1'b0;
	logic         cfg_addr = 1'b0;
	logic [63:0]  cfg_wdata = '0;

	nbody_energy_momentum_diagnostics_core uut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// stimulus and expectations
	body_t body_q[$];
	diag_t diag_q[$];
	int    errors = 0;
	int    bodies_sent = 0;
	int    systems_sent = 0;
	int    diags_seen = 0;
	int    cfg_writes = 0;
	int    status_hits[5] = '{default: 0};
	bit    quiet_tx = 0;
	bit    quiet_rx = 0;

	// predictor state
	q32_t g_shadow = G_RESET;
	q32_t eps_shadow = '0;
	q32_t mass_mem[MAX_BODIES];
	q32_t px_mem[MAX_BODIES];
	q32_t py_mem[MAX_BODIES];
	q32_t pz_mem[MAX_BODIES];
	int   n_stored = 0;
	q32_t ke_sum = '0;
	q32_t mom_sum[3] = '{default: '0};
	q32_t mpos_sum[3] = '{default: '0};
	q32_t mtot_sum = '0;

	// ------------------------------------------------------------------------
	// Q32.32 arithmetic
	// ------------------------------------------------------------------------
	function automatic q32_t clamp64(wide_t x);
		if (x > wide_t'(S64_MAX)) return S64_MAX;
		if (x < wide_t'(S64_MIN)) return S64_MIN;
		return x[63:0];
	endfunction

	function automatic q32_t add_sat(q32_t a, q32_t b);
		return clamp64(wide_t'(a) + wide_t'(b));
	endfunction

	function automatic q32_t sub_sat(q32_t a, q32_t b);
		return clamp64(wide_t'(a) - wide_t'(b));
	endfunction

	// floor(a*b / 2^sh), saturated
	function automatic q32_t mul_q(q32_t a, q32_t b, int sh);
		wide_t prod;
		prod = wide_t'(a) * wide_t'(b);
		return clamp64(prod >>> sh);
	endfunction

	// (num * 2^32) / den toward zero, saturated
	function automatic q32_t div_q(q32_t num, q32_t den);
		wide_t n;
		n = wide_t'(num) <<< 32;
		return clamp64(n / wide_t'(den));
	endfunction

	// floor(sqrt(s * 2^32)) for s >= 0
	function automatic q32_t sqrt_q(q32_t s);
		logic [127:0] target;
		logic [127:0] c;
		logic [63:0]  r;
		r = '0;
		target = {64'd0, s} << 32;
		for (int b = 47; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= target) r = c[63:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Per-body accumulation and end-of-system diagnostics
	// ------------------------------------------------------------------------
	task automatic absorb_body(body_t b);
		q32_t  v2, eps2, gm, dx, dy, dz, s, sep;
		q32_t  pot;
		diag_t d;
		status_t st;
		bit    stop;
		v2 = '0;
		pot = '0;
		st = ST_OK;
		stop = 0;
		if (n_stored < MAX_BODIES) begin
			for (int k = 0; k < 3; k++) begin
				v2 = add_sat(v2, mul_q(b.v[k], b.v[k], 32));
				mom_sum[k] = add_sat(mom_sum[k], mul_q(b.m, b.v[k], 32));
				mpos_sum[k] = add_sat(mpos_sum[k], mul_q(b.m, b.p[k], 32));
			end
			ke_sum = add_sat(ke_sum, mul_q(b.m, v2, 33));
			mtot_sum = add_sat(mtot_sum, b.m);
			mass_mem[n_stored] = b.m;
			px_mem[n_stored] = b.p[0];
			py_mem[n_stored] = b.p[1];
			pz_mem[n_stored] = b.p[2];
			n_stored++;
		end
		if (!b.last) return;

		// softened pair sweep
		if (g_shadow <= 0) st = ST_BAD_G;
		else if (eps_shadow < 0) st = ST_NEG_EPS;
		else begin
			eps2 = mul_q(eps_shadow, eps_shadow, 32);
			for (int i = 0; i < n_stored && !stop; i++) begin
				gm = mul_q(g_shadow, mass_mem[i], 32);
				for (int j = i + 1; j < n_stored && !stop; j++) begin
					dx = sub_sat(px_mem[j], px_mem[i]);
					dy = sub_sat(py_mem[j], py_mem[i]);
					dz = sub_sat(pz_mem[j], pz_mem[i]);
					s = mul_q(dx, dx, 32);
					s = add_sat(s, mul_q(dy, dy, 32));
					s = add_sat(s, mul_q(dz, dz, 32));
					s = add_sat(s, eps2);
					sep = sqrt_q(s);
					if (sep == 0) begin
						st = ST_COINCIDE;
						stop = 1;
					end else begin
						pot = sub_sat(pot, div_q(mul_q(gm, mass_mem[j], 32), sep));
					end
				end
			end
		end
		if (st != ST_OK) pot = '0;
		d.f[0] = ke_sum;
		d.f[1] = pot;
		d.f[2] = (st != ST_OK) ? q32_t'(0) : add_sat(ke_sum, pot);
		for (int k = 0; k < 3; k++) begin
			d.f[3 + k] = mom_sum[k];
			d.f[6 + k] = (mtot_sum == 0) ? q32_t'(0) : div_q(mpos_sum[k], mtot_sum);
		end
		if (mtot_sum == 0 && st == ST_OK) st = ST_ZERO_M;
		d.st = st;
		diag_q.push_back(d);

		// next system starts empty
		n_stored = 0;
		ke_sum = '0;
		mtot_sum = '0;
		mom_sum = '{default: '0};
		mpos_sum = '{default: '0};
	endtask

	// ------------------------------------------------------------------------
	// Driver: one body request at a time, random gap before each
	// ------------------------------------------------------------------------
	int    tx_gap = 0;
	body_t tx_cur;

	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			tx_gap = 0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				absorb_body(tx_cur);
				busy = 0;
				tx_gap = quiet_tx ? 0 : $urandom_range(0, 17);
			end
			if (!busy) begin
				if (tx_gap > 0) tx_gap--;
				else if (body_q.size() > 0) begin
					tx_cur = body_q.pop_front();
					s_tdata <= {tx_cur.v[2], tx_cur.v[1], tx_cur.v[0],
						tx_cur.p[2], tx_cur.p[1], tx_cur.p[0], tx_cur.m};
					s_tlast <= tx_cur.last;
					busy = 1;
				end
			end
			s_tvalid <= busy;
		end
	end

	// ------------------------------------------------------------------------
	// Long receiver hold after the twentieth result, to back up the core
	// ------------------------------------------------------------------------
	int   hold_left = 0;
	int   hold_seen = 0;
	logic hold_rx = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left = 0;
			hold_seen = 0;
			hold_rx <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				hold_seen++;
				if (hold_seen == 20) hold_left = LONG_HOLD;
			end
			if (hold_left > 0) hold_left--;
			hold_rx <= (hold_left > 0);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random stalls between results
	// ------------------------------------------------------------------------
	int rx_stall = 0;

	always @(posedge clk or negedge arst_n) begin
		diag_t  exp_d;
		q32_t   got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				diags_seen++;
				if (diag_q.size() == 0) begin
					$display("%0t: unexpected diagnostics request, actual %h", $realtime,
						m_tdata);
					errors++;
				end else begin
					exp_d = diag_q.pop_front();
					for (int k = 0; k < 9; k++) begin
						got = m_tdata[64*k +: 64];
						if (got !== exp_d.f[k]) begin
							$display("%0t: field %0d expected %h actual %h", $realtime, k,
								exp_d.f[k], got);
							errors++;
						end
					end
					if (m_tdata[578:576] !== exp_d.st) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							exp_d.st, m_tdata[578:576]);
						errors++;
					end
					status_hits[exp_d.st]++;
				end
				rx_stall = quiet_rx ? 0 : $urandom_range(0, 17);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !hold_rx;
			end
		end
	end

	// watchdog on accepted requests
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("nbody_energy_momentum_diagnostics_core: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_body(q32_t m, q32_t px, q32_t py, q32_t pz,
		q32_t vx, q32_t vy, q32_t vz, logic last);
		body_t b;
		b.m = m;
		b.p = '{px, py, pz};
		b.v = '{vx, vy, vz};
		b.last = last;
		body_q.push_back(b);
		bodies_sent++;
		if (last) systems_sent++;
	endtask

	task automatic wait_idle();
		while (body_q.size() != 0 || s_tvalid || diag_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, q32_t val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRAV) g_shadow = val;
		else eps_shadow = val;
		cfg_writes++;
	endtask

	// mostly moderate magnitudes, some full-width and extreme values
	function automatic q32_t rnd_q();
		q32_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return v;
			1: case ($urandom_range(0, 4))
				0: return S64_MAX;
				1: return S64_MIN;
				2: return '0;
				3: return 64'sd1;
				default: return -64'sd1;
			endcase
			default: return v >>> $urandom_range(16, 40);
		endcase
	endfunction

	task automatic queue_random_system();
		int   n, flavor;
		q32_t m, prev_m;
		q32_t pp[3];
		prev_m = '0;
		n = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
		flavor = $urandom_range(0, 11);
		for (int i = 0; i < n; i++) begin
			m = rnd_q();
			// masses that cancel out
			if (flavor == 1) begin
				if (i % 2) m = -prev_m;
				else if (i == n - 1) m = '0;
			end
			// duplicate the previous position
			if (!(flavor == 0 && i > 0)) pp = '{rnd_q(), rnd_q(), rnd_q()};
			push_body(m, pp[0], pp[1], pp[2], rnd_q(), rnd_q(), rnd_q(), i == n - 1);
			prev_m = m;
		end
	endtask

	// store overflow; first two bodies coincide so the sweep stops early
	task automatic queue_full_system(int n);
		for (int i = 0; i < n; i++) begin
			push_body(rnd_q(), (i < 2) ? ONE : rnd_q(), (i < 2) ? -ONE : rnd_q(),
				(i < 2) ? q32_t'(0) : rnd_q(), rnd_q(), rnd_q(), rnd_q(), i == n - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int sys_in_phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings
		push_body(S64_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MAX, 1'b1);
		push_body(ONE, 0, 0, 0, ONE, 0, 0, 1'b0);
		push_body(ONE, ONE, 0, 0, 0, -ONE, 0, 1'b1);
		push_body(2 * ONE, ONE, ONE, ONE, 0, 0, 0, 1'b0);
		push_body(ONE, ONE, ONE, ONE, 0, 0, 0, 1'b1);
		push_body(0, ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, 1'b1);
		push_body(-3 * ONE, ONE, 0, 0, ONE, 0, 0, 1'b0);
		push_body(3 * ONE, -ONE, 0, 0, ONE, 0, 0, 1'b1);
		push_body(S64_MIN, -64'sd1, 64'sd1, S64_MIN, -64'sd1, S64_MIN, 64'sd1, 1'b0);
		push_body(S64_MAX, S64_MAX, -64'sd1, 0, S64_MAX, 64'sd1, -64'sd1, 1'b1);

		// directed: settings at their extremes
		write_reg(REG_GRAV, '0);
		push_body(ONE, 0, 0, 0, ONE, 0, 0, 1'b1);
		write_reg(REG_GRAV, S64_MIN);
		push_body(ONE, ONE, 0, 0, 0, 0, 0, 1'b1);
		write_reg(REG_GRAV, ONE);
		write_reg(REG_SOFT, -64'sd1);
		push_body(ONE, 0, 0, 0, 0, 0, 0, 1'b0);
		push_body(ONE, ONE, 0, 0, 0, 0, 0, 1'b1);
		// softening too small to register still counts as zero
		write_reg(REG_SOFT, 64'sd1);
		push_body(ONE, ONE, ONE, 0, 0, 0, 0, 1'b0);
		push_body(ONE, ONE, ONE, 0, 0, 0, 0, 1'b1);
		write_reg(REG_SOFT, ONE);
		push_body(ONE, ONE, ONE, 0, 0, 0, 0, 1'b0);
		push_body(ONE, ONE, ONE, 0, 0, 0, 0, 1'b1);
		write_reg(REG_GRAV, S64_MAX);
		write_reg(REG_SOFT, S64_MAX);
		push_body(S64_MAX, 0, 0, 0, 0, 0, 0, 1'b0);
		push_body(S64_MAX, S64_MAX, 0, 0, 0, 0, 0, 1'b1);

		// store overflow, with a good and a bad constant
		write_reg(REG_SOFT, '0);
		write_reg(REG_GRAV, ONE);
		queue_full_system(MAX_BODIES + 1);
		write_reg(REG_GRAV, -ONE);
		queue_full_system(MAX_BODIES + 4);

		// random systems, settings changed between phases
		sys_in_phase = 0;
		write_reg(REG_GRAV, ONE);
		while (bodies_sent < 1300) begin
			if (sys_in_phase == 20) begin
				sys_in_phase = 0;
				quiet_tx = ($urandom_range(0, 3) == 0);
				quiet_rx = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 5))
					0: write_reg(REG_GRAV, S64_MAX);
					1: write_reg(REG_GRAV, -q32_t'($urandom));
					2: write_reg(REG_GRAV, 64'sd1);
					default: write_reg(REG_GRAV, q32_t'({$urandom}) <<< $urandom_range(0, 8));
				endcase
				case ($urandom_range(0, 5))
					0: write_reg(REG_SOFT, -q32_t'($urandom_range(1, 1000)));
					1: write_reg(REG_SOFT, S64_MAX);
					2: write_reg(REG_SOFT, 64'sd1);
					3: write_reg(REG_SOFT, q32_t'({$urandom}) <<< $urandom_range(0, 30));
					default: write_reg(REG_SOFT, '0);
				endcase
			end
			queue_random_system();
			sys_in_phase++;
			while (body_q.size() > 40) @(posedge clk);
		end

		wait_idle();
		repeat (300) @(posedge clk);
		$display("Sent %0d bodies in %0d systems over %0d register writes; %0d results checked.",
			bodies_sent, systems_sent, cfg_writes, diags_seen);
		$display("Status counts ok/bad G/neg eps/coincident/zero mass: %0d %0d %0d %0d %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
		if (errors == 0) begin
			$display("nbody_energy_momentum_diagnostics_core: match");
		end else begin
			$display("nbody_energy_momentum_diagnostics_core: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nbem_pkg.sv
hw/rtl/nbem_mul.sv
hw/rtl/nbem_dsq.sv
hw/rtl/nbody_energy_momentum_diagnostics_core.sv
hw/rtl/nbem_checker.sv
sim/nbody_energy_momentum_diagnostics_core_tb.sv
